// File: sv/bary_pkg.sv
// Shared widths, word types and pipeline structs for the barycentric block.
package bary_pkg;

    localparam int W  = 32;            // coordinate width
    localparam int DW = W + 1;         // edge vector component
    localparam int PW = 2 * DW + 2;    // dot product
    localparam int GW = 2 * PW + 1;    // Gram determinant and numerators
    localparam int MW = GW;            // magnitudes
    localparam int RW = MW + W + 3;    // divider remainder
    localparam int QW = W + 2;         // quotient bits

    typedef struct packed {
        logic signed [W-1:0] point_x;
        logic signed [W-1:0] point_y;
        logic signed [W-1:0] point_z;
        logic signed [W-1:0] vert_a_x;
        logic signed [W-1:0] vert_a_y;
        logic signed [W-1:0] vert_a_z;
        logic signed [W-1:0] vert_b_x;
        logic signed [W-1:0] vert_b_y;
        logic signed [W-1:0] vert_b_z;
        logic signed [W-1:0] vert_c_x;
        logic signed [W-1:0] vert_c_y;
        logic signed [W-1:0] vert_c_z;
    } query_t;

    typedef struct packed {
        logic signed [W-1:0] weight_b;
        logic signed [W-1:0] weight_c;
        logic signed [W-1:0] weight_a;
        logic                degenerate;
    } weights_t;

    typedef struct packed {
        logic signed [PW-1:0] d00;
        logic signed [PW-1:0] d01;
        logic signed [PW-1:0] d11;
        logic signed [PW-1:0] d20;
        logic signed [PW-1:0] d21;
    } dots_t;

    typedef struct packed {
        logic deg;
        logic neg;
    } tag_t;

    typedef struct packed {
        logic          deg;
        logic          neg_b;
        logic          neg_c;
        logic [RW-1:0] n_b;
        logic [RW-1:0] n_c;
        logic [RW-1:0] d2;
    } div_in_t;

endpackage

// File: sv/bary_front.sv
// Edge vectors and the five dot products, three register stages.
module bary_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  bary_pkg::query_t  query,
    output logic              out_valid,
    output bary_pkg::dots_t   dots
);
    localparam int W  = bary_pkg::W;
    localparam int DW = bary_pkg::DW;
    localparam int PW = bary_pkg::PW;
    localparam int XW = 2 * DW;

    logic                 v1_reg, v2_reg, v3_reg;
    logic signed [DW-1:0] e0_reg [3];
    logic signed [DW-1:0] e1_reg [3];
    logic signed [DW-1:0] e2_reg [3];
    logic signed [XW-1:0] p00_reg [3];
    logic signed [XW-1:0] p01_reg [3];
    logic signed [XW-1:0] p11_reg [3];
    logic signed [XW-1:0] p20_reg [3];
    logic signed [XW-1:0] p21_reg [3];
    bary_pkg::dots_t      dots_reg;

    logic signed [W-1:0] a_c [3];
    logic signed [W-1:0] b_c [3];
    logic signed [W-1:0] c_c [3];
    logic signed [W-1:0] p_c [3];

    always_comb
    begin
        a_c[0] = query.vert_a_x; a_c[1] = query.vert_a_y; a_c[2] = query.vert_a_z;
        b_c[0] = query.vert_b_x; b_c[1] = query.vert_b_y; b_c[2] = query.vert_b_z;
        c_c[0] = query.vert_c_x; c_c[1] = query.vert_c_y; c_c[2] = query.vert_c_z;
        p_c[0] = query.point_x;  p_c[1] = query.point_y;  p_c[2] = query.point_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            e0_reg[i] <= DW'(b_c[i]) - DW'(a_c[i]);
            e1_reg[i] <= DW'(c_c[i]) - DW'(a_c[i]);
            e2_reg[i] <= DW'(p_c[i]) - DW'(a_c[i]);
            p00_reg[i] <= e0_reg[i] * e0_reg[i];
            p01_reg[i] <= e0_reg[i] * e1_reg[i];
            p11_reg[i] <= e1_reg[i] * e1_reg[i];
            p20_reg[i] <= e2_reg[i] * e0_reg[i];
            p21_reg[i] <= e2_reg[i] * e1_reg[i];
        end
        dots_reg.d00 <= PW'(p00_reg[0]) + PW'(p00_reg[1]) + PW'(p00_reg[2]);
        dots_reg.d01 <= PW'(p01_reg[0]) + PW'(p01_reg[1]) + PW'(p01_reg[2]);
        dots_reg.d11 <= PW'(p11_reg[0]) + PW'(p11_reg[1]) + PW'(p11_reg[2]);
        dots_reg.d20 <= PW'(p20_reg[0]) + PW'(p20_reg[1]) + PW'(p20_reg[2]);
        dots_reg.d21 <= PW'(p21_reg[0]) + PW'(p21_reg[1]) + PW'(p21_reg[2]);
    end

    assign out_valid = v3_reg;
    assign dots      = dots_reg;

endmodule

// File: sv/bary_gram.sv
// Gram determinant, numerators and divider operands, four register stages.
module bary_gram
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  bary_pkg::dots_t    dots,
    output logic               out_valid,
    output bary_pkg::div_in_t  div_in
);
    localparam int PW = bary_pkg::PW;
    localparam int GW = bary_pkg::GW;
    localparam int MW = bary_pkg::MW;
    localparam int RW = bary_pkg::RW;
    localparam int XW = 2 * PW;
    localparam int LW = PW / 2;          // limb width
    localparam int KW = 2 * (LW + 1);    // limb product

    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [KW-1:0] hh_reg [6];
    logic signed [KW-1:0] hl_reg [6];
    logic signed [KW-1:0] lh_reg [6];
    logic signed [KW-1:0] ll_reg [6];
    logic signed [XW-1:0] m_reg [6];
    logic signed [GW-1:0] den_reg, numb_reg, numc_reg;
    bary_pkg::div_in_t    div_reg;

    logic signed [PW-1:0] opa [6];
    logic signed [PW-1:0] opb [6];
    logic signed [LW:0]   ah [6];
    logic signed [LW:0]   al [6];
    logic signed [LW:0]   bh [6];
    logic signed [LW:0]   bl [6];

    logic [MW-1:0] den_mag, numb_mag, numc_mag;

    // product order: d00*d11, d01*d01, d11*d20, d01*d21, d00*d21, d01*d20
    // each operand splits into a signed high limb and an unsigned low limb
    always_comb
    begin
        opa[0] = dots.d00; opb[0] = dots.d11;
        opa[1] = dots.d01; opb[1] = dots.d01;
        opa[2] = dots.d11; opb[2] = dots.d20;
        opa[3] = dots.d01; opb[3] = dots.d21;
        opa[4] = dots.d00; opb[4] = dots.d21;
        opa[5] = dots.d01; opb[5] = dots.d20;
        for (int k = 0; k < 6; k++)
        begin
            ah[k] = {opa[k][PW-1], opa[k][PW-1:LW]};
            al[k] = {1'b0, opa[k][LW-1:0]};
            bh[k] = {opb[k][PW-1], opb[k][PW-1:LW]};
            bl[k] = {1'b0, opb[k][LW-1:0]};
        end
    end

    assign den_mag  = den_reg[GW-1]  ? MW'(-den_reg)  : MW'(den_reg);
    assign numb_mag = numb_reg[GW-1] ? MW'(-numb_reg) : MW'(numb_reg);
    assign numc_mag = numc_reg[GW-1] ? MW'(-numc_reg) : MW'(numc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 6; k++)
        begin
            hh_reg[k] <= ah[k] * bh[k];
            hl_reg[k] <= ah[k] * bl[k];
            lh_reg[k] <= al[k] * bh[k];
            ll_reg[k] <= al[k] * bl[k];
            m_reg[k]  <= (XW'(hh_reg[k]) <<< (2 * LW))
                       + ((XW'(hl_reg[k]) + XW'(lh_reg[k])) <<< LW)
                       + XW'(ll_reg[k]);
        end

        den_reg  <= GW'(m_reg[0]) - GW'(m_reg[1]);
        numb_reg <= GW'(m_reg[2]) - GW'(m_reg[3]);
        numc_reg <= GW'(m_reg[4]) - GW'(m_reg[5]);

        // rounded quotient: (2*|num|*2^F + |den|) / (2*|den|)
        div_reg.deg   <= (den_reg == '0);
        div_reg.neg_b <= numb_reg[GW-1] ^ den_reg[GW-1];
        div_reg.neg_c <= numc_reg[GW-1] ^ den_reg[GW-1];
        div_reg.n_b   <= (RW'(numb_mag) << (FRAC_BITS + 1)) + RW'(den_mag);
        div_reg.n_c   <= (RW'(numc_mag) << (FRAC_BITS + 1)) + RW'(den_mag);
        div_reg.d2    <= RW'(den_mag) << 1;
    end

    assign out_valid = v4_reg;
    assign div_in    = div_reg;

endmodule

// File: sv/bary_div.sv
// Restoring divider, one quotient bit per register stage.
module bary_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  bary_pkg::tag_t               in_tag,
    input  logic [bary_pkg::RW-1:0]      num,
    input  logic [bary_pkg::RW-1:0]      den,
    output logic                         out_valid,
    output bary_pkg::tag_t               out_tag,
    output logic [bary_pkg::QW-1:0]      quot
);
    localparam int RW = bary_pkg::RW;
    localparam int QW = bary_pkg::QW;

    logic            v_reg [QW];
    bary_pkg::tag_t  t_reg [QW];
    logic [RW-1:0]   r_reg [QW];
    logic [RW-1:0]   d_reg [QW];
    logic [QW-1:0]   q_reg [QW];

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic            v_in;
        bary_pkg::tag_t  t_in;
        logic [RW-1:0]   r_in, d_in, dsh;
        logic [QW-1:0]   q_in;
        logic            ge;

        if (s == 0)
        begin : g_first
            assign v_in = in_valid;
            assign t_in = in_tag;
            assign r_in = num;
            assign d_in = den;
            assign q_in = '0;
        end
        else
        begin : g_next
            assign v_in = v_reg[s-1];
            assign t_in = t_reg[s-1];
            assign r_in = r_reg[s-1];
            assign d_in = d_reg[s-1];
            assign q_in = q_reg[s-1];
        end

        assign dsh = d_in << (QW - 1 - s);
        assign ge  = (r_in >= dsh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else
            begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            t_reg[s] <= t_in;
            d_reg[s] <= d_in;
            r_reg[s] <= ge ? r_in - dsh : r_in;
            q_reg[s] <= q_in | (QW'(ge) << (QW - 1 - s));
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_tag   = t_reg[QW-1];
    assign quot      = q_reg[QW-1];

endmodule

// File: sv/barycentric_coordinates.sv
// Throughput: one word per cycle; the 34-stage divider pair is fully pipelined.
// busy is always low; done pulses one cycle with the result word.
// Reset: rst_n asynchronous active low clears all valid bits; no words emerge
// until the first accepted query has crossed the pipe.
// Top level: dot products, Gram stage, two dividers, saturation and output register.
module barycentric_coordinates
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  bary_pkg::query_t    query,
    output logic                done,
    output bary_pkg::weights_t  weights
);
    localparam int W   = bary_pkg::W;
    localparam int QW  = bary_pkg::QW;
    localparam int LAT = 3 + 4 + QW + 1;

    logic               fr_valid, gr_valid, db_valid, dc_valid;
    bary_pkg::dots_t    dots;
    bary_pkg::div_in_t  div_in;
    bary_pkg::tag_t     tag_b_in, tag_c_in, tag_b, tag_c;
    logic [QW-1:0]      q_b, q_c;

    logic               done_reg;
    bary_pkg::weights_t weights_reg, weights_next;

    assign busy = 1'b0;

    bary_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .query     (query),
        .out_valid (fr_valid),
        .dots      (dots)
    );

    bary_gram #(.FRAC_BITS(FRAC_BITS)) u_gram
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .dots      (dots),
        .out_valid (gr_valid),
        .div_in    (div_in)
    );

    assign tag_b_in = '{deg: div_in.deg, neg: div_in.neg_b};
    assign tag_c_in = '{deg: div_in.deg, neg: div_in.neg_c};

    bary_div u_div_b
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (gr_valid),
        .in_tag    (tag_b_in),
        .num       (div_in.n_b),
        .den       (div_in.d2),
        .out_valid (db_valid),
        .out_tag   (tag_b),
        .quot      (q_b)
    );

    bary_div u_div_c
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (gr_valid),
        .in_tag    (tag_c_in),
        .num       (div_in.n_c),
        .den       (div_in.d2),
        .out_valid (dc_valid),
        .out_tag   (tag_c),
        .quot      (q_c)
    );

    // saturate a quotient magnitude and apply its sign
    function automatic logic signed [W-1:0] sat_q(input logic [QW-1:0] q, input logic neg);
        logic [QW-1:0] lim;
        logic [QW-1:0] mag;
        lim = neg ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - QW'(1));
        mag = (q > lim) ? lim : q;
        return neg ? W'(-mag) : W'(mag);
    endfunction

    logic signed [W-1:0] wb_c, wc_c;
    logic signed [W+1:0] wa_wide;
    logic signed [W+1:0] hi_lim, lo_lim;

    always_comb
    begin
        wb_c    = sat_q(q_b, tag_b.neg);
        wc_c    = sat_q(q_c, tag_c.neg);
        hi_lim  = (W + 2)'((W + 2)'(1) << (W - 1)) - (W + 2)'(1);
        lo_lim  = -hi_lim - (W + 2)'(1);
        wa_wide = ((W + 2)'(1) << FRAC_BITS) - (W + 2)'(wb_c) - (W + 2)'(wc_c);

        weights_next.weight_b   = wb_c;
        weights_next.weight_c   = wc_c;
        weights_next.degenerate = tag_b.deg;
        if (wa_wide > hi_lim)
        begin
            weights_next.weight_a = W'(hi_lim);
        end
        else if (wa_wide < lo_lim)
        begin
            weights_next.weight_a = W'(lo_lim);
        end
        else
        begin
            weights_next.weight_a = W'(wa_wide);
        end

        // collinear or coincident vertices: flag and zero weights
        if (tag_b.deg)
        begin
            weights_next.weight_b = '0;
            weights_next.weight_c = '0;
            weights_next.weight_a = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= db_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        weights_reg <= weights_next;
    end

    assign done    = done_reg;
    assign weights = weights_reg;

    // both dividers move in lockstep
    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        db_valid == dc_valid)
        else $error("divider valid bits diverged");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LAT done)
        else $error("result word missing after fixed latency");

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && weights.degenerate |->
            weights.weight_a == '0 && weights.weight_b == '0 && weights.weight_c == '0)
        else $error("degenerate word carries nonzero weights");

endmodule

// File: test/tb_barycentric_coordinates.sv
// Testbench for barycentric_coordinates: directed table plus random queries.
`timescale 1ns / 1ps

module tb_barycentric_coordinates;

    localparam int W         = bary_pkg::W;
    localparam int FRAC      = 16;
    localparam int N_RANDOM  = 1600;
    localparam int TAIL_WAIT = 60;       // exceeds the pipe latency

    typedef logic signed [255:0] wide_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    bary_pkg::query_t   query;
    logic               done;
    bary_pkg::weights_t weights;

    bary_pkg::weights_t expected_weights[$];
    int                 mismatch_count;
    bit                 failed;

    bary_pkg::query_t   dir_query[$];
    bary_pkg::weights_t dir_weights[$];
    bit                 dir_known[$];

    barycentric_coordinates u_top
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .query   (query),
        .done    (done),
        .weights (weights)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Sign-extend one coordinate to the working width.
    function automatic wide_t sx(input logic signed [W-1:0] v);
        return {{(256-W){v[W-1]}}, v};
    endfunction

    // round(num * 2^FRAC / den), ties away from zero, saturated to W bits.
    function automatic logic signed [W-1:0] ratio_q16(input wide_t num, input wide_t den);
        logic         neg;
        wide_t        n_mag;
        wide_t        d_mag;
        logic [255:0] quo;
        logic [255:0] lim;
        neg   = num[255] ^ den[255];
        n_mag = num[255] ? -num : num;
        d_mag = den[255] ? -den : den;
        quo   = ((n_mag <<< (FRAC + 1)) + d_mag) / (d_mag <<< 1);
        lim   = neg ? (256'd1 << (W - 1)) : ((256'd1 << (W - 1)) - 1);
        if (quo > lim)
            quo = lim;
        return neg ? -quo[W-1:0] : quo[W-1:0];
    endfunction

    function automatic bary_pkg::weights_t predict_weights(input bary_pkg::query_t q);
        wide_t              e0[3];
        wide_t              e1[3];
        wide_t              e2[3];
        wide_t              d00, d01, d11, d20, d21, den;
        longint             wa;
        bary_pkg::weights_t r;
        e0[0] = sx(q.vert_b_x) - sx(q.vert_a_x);
        e0[1] = sx(q.vert_b_y) - sx(q.vert_a_y);
        e0[2] = sx(q.vert_b_z) - sx(q.vert_a_z);
        e1[0] = sx(q.vert_c_x) - sx(q.vert_a_x);
        e1[1] = sx(q.vert_c_y) - sx(q.vert_a_y);
        e1[2] = sx(q.vert_c_z) - sx(q.vert_a_z);
        e2[0] = sx(q.point_x) - sx(q.vert_a_x);
        e2[1] = sx(q.point_y) - sx(q.vert_a_y);
        e2[2] = sx(q.point_z) - sx(q.vert_a_z);
        d00 = e0[0]*e0[0] + e0[1]*e0[1] + e0[2]*e0[2];
        d01 = e0[0]*e1[0] + e0[1]*e1[1] + e0[2]*e1[2];
        d11 = e1[0]*e1[0] + e1[1]*e1[1] + e1[2]*e1[2];
        d20 = e2[0]*e0[0] + e2[1]*e0[1] + e2[2]*e0[2];
        d21 = e2[0]*e1[0] + e2[1]*e1[1] + e2[2]*e1[2];
        den = d00*d11 - d01*d01;
        r = '0;
        if (den == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        r.weight_b = ratio_q16(d11*d20 - d01*d21, den);
        r.weight_c = ratio_q16(d00*d21 - d01*d20, den);
        wa = (longint'(1) << FRAC) - longint'(r.weight_b) - longint'(r.weight_c);
        if (wa > 64'sh7FFFFFFF)
            wa = 64'sh7FFFFFFF;
        else if (wa < -64'sh80000000)
            wa = -64'sh80000000;
        r.weight_a = wa[W-1:0];
        return r;
    endfunction

    function automatic bary_pkg::query_t make_query(
        input logic [W-1:0] px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz);
        bary_pkg::query_t q;
        q = {px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz};
        return q;
    endfunction

    function automatic bary_pkg::weights_t make_weights(
        input logic [W-1:0] wb, wc, wa, input logic deg);
        bary_pkg::weights_t r;
        r = {wb, wc, wa, deg};
        return r;
    endfunction

    // Append one directed row; known rows carry their expected word.
    task automatic add_row(input bary_pkg::query_t q, input bit known,
                           input bary_pkg::weights_t w);
        dir_query   = {dir_query, q};
        dir_known   = {dir_known, known};
        dir_weights = {dir_weights, w};
    endtask

    // Small signed Q16.16 value, mostly within a few units.
    function automatic logic [W-1:0] near_coord();
        return $urandom_range(0, 3) == 0 ? $urandom
                                         : ($urandom & 32'h0007_FFFF) - 32'h0004_0000;
    endfunction

    function automatic bary_pkg::query_t random_query();
        bary_pkg::query_t q;
        logic [W-1:0]     dx, dy, dz;
        int               sel;
        sel = $urandom_range(0, 9);
        q = make_query(near_coord(), near_coord(), near_coord(), near_coord(),
                       near_coord(), near_coord(), near_coord(), near_coord(),
                       near_coord(), near_coord(), near_coord(), near_coord());
        if (sel < 2)
        begin
            // full-range noise
            q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end
        else if (sel == 2)
        begin
            // collinear: C = A + 2(B-A)
            dx = $urandom_range(0, 65535) - 32768;
            dy = $urandom_range(0, 65535) - 32768;
            dz = $urandom_range(0, 3) == 0 ? 32'd0 : $urandom_range(0, 65535) - 32768;
            q.vert_b_x = q.vert_a_x + dx;
            q.vert_b_y = q.vert_a_y + dy;
            q.vert_b_z = q.vert_a_z + dz;
            q.vert_c_x = q.vert_a_x + 2 * dx;
            q.vert_c_y = q.vert_a_y + 2 * dy;
            q.vert_c_z = q.vert_a_z + 2 * dz;
        end
        else if (sel == 3)
        begin
            // coincident B and A
            q.vert_b_x = q.vert_a_x;
            q.vert_b_y = q.vert_a_y;
            q.vert_b_z = q.vert_a_z;
        end
        else if (sel == 4)
        begin
            // tiny triangle, far point: drives saturation
            q.vert_b_x = q.vert_a_x + $urandom_range(1, 4);
            q.vert_b_y = q.vert_a_y;
            q.vert_b_z = q.vert_a_z;
            q.vert_c_x = q.vert_a_x;
            q.vert_c_y = q.vert_a_y + $urandom_range(1, 4);
            q.vert_c_z = q.vert_a_z;
            q.point_x  = $urandom;
            q.point_y  = $urandom;
        end
        return q;
    endfunction

    // Result checker: done words are compared in order against the queue.
    always @(posedge clk)
    begin
        bary_pkg::weights_t exp_w;
        if (rst_n && done)
        begin
            if (expected_weights.size() == 0)
            begin
                failed = 1'b1;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected word: %h", weights);
            end
            else
            begin
                exp_w = expected_weights.pop_front();
                if (weights !== exp_w)
                begin
                    failed = 1'b1;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp b=%h c=%h a=%h deg=%b, got b=%h c=%h a=%h deg=%b",
                                 exp_w.weight_b, exp_w.weight_c, exp_w.weight_a,
                                 exp_w.degenerate, weights.weight_b, weights.weight_c,
                                 weights.weight_a, weights.degenerate);
                end
            end
        end
    end

    // Present one word at the falling edge and hold it until taken.
    task automatic send_query(input bary_pkg::query_t q, input bary_pkg::weights_t w);
        @(negedge clk);
        start <= 1'b1;
        query <= q;
        while (busy)
            @(negedge clk);
        expected_weights = {expected_weights, w};
    endtask

    task automatic idle_gap();
        int n;
        if ($urandom_range(0, 9) < 6)
            n = 0;
        else if ($urandom_range(0, 9) == 0)
            n = $urandom_range(10, 60);
        else
            n = $urandom_range(1, 3);
        if (n > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    localparam logic [W-1:0] ONE  = 32'h0001_0000;
    localparam logic [W-1:0] MAXC = 32'h7FFF_FFFF;
    localparam logic [W-1:0] MINC = 32'h8000_0000;

    initial
    begin
        bary_pkg::weights_t w;
        bary_pkg::query_t   q;

        start          = 1'b0;
        query          = '0;
        rst_n          = 1'b0;
        failed         = 1'b0;
        mismatch_count = 0;

        // All-zero triangle: degenerate, zero weights.
        add_row('0, 1'b1, make_weights(0, 0, 0, 1'b1));
        // Unit right triangle, point at each vertex.
        add_row(make_query(0, 0, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0), 1'b1,
                make_weights(0, 0, ONE, 1'b0));
        add_row(make_query(ONE, 0, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0), 1'b1,
                make_weights(ONE, 0, 0, 1'b0));
        add_row(make_query(0, ONE, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0), 1'b1,
                make_weights(0, ONE, 0, 1'b0));
        // All coordinates at the negative extreme: degenerate.
        add_row({12{MINC}}, 1'b1, make_weights(0, 0, 0, 1'b1));
        // All at the positive extreme: degenerate.
        add_row({12{MAXC}}, 1'b1, make_weights(0, 0, 0, 1'b1));
        // One-LSB triangle, point at the negative limit: b saturates low, a high.
        add_row(make_query(MINC, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0), 1'b1,
                make_weights(MINC, 0, MAXC, 1'b0));
        // Remaining rows go through the predictor.
        add_row(make_query(MAXC, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0), 1'b0, '0);
        add_row(make_query(0, MAXC, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0), 1'b0, '0);
        add_row(make_query(MAXC, MAXC, MAXC, MINC, MINC, MINC,
                           MAXC, MINC, MINC, MINC, MAXC, MINC), 1'b0, '0);
        add_row(make_query(MINC, MAXC, MINC, MAXC, MAXC, MAXC,
                           MINC, MAXC, MAXC, MAXC, MINC, MINC), 1'b0, '0);
        add_row(make_query(ONE >> 1, ONE >> 1, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0), 1'b0, '0);
        add_row(make_query(1, 1, 1, 0, 0, 0, 3, 0, 0, 0, 3, 0), 1'b0, '0);
        add_row(make_query(-ONE, -ONE, ONE, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1'b0, '0);
        add_row(make_query(ONE, ONE, ONE, 0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE,
                           2*ONE), 1'b0, '0);
        add_row(make_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           32'hAAAA_AAAA, 32'h5555_5555, 0,
                           32'h5555_5555, 32'hAAAA_AAAA, 0, 0, 0, 32'h1234_5678),
                1'b0, '0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_query[i])
        begin
            w = dir_known[i] ? dir_weights[i] : predict_weights(dir_query[i]);
            send_query(dir_query[i], w);
            idle_gap();
        end

        for (int i = 0; i < N_RANDOM; i++)
        begin
            // Drain the pipe once mid-run.
            if (i == N_RANDOM / 2)
            begin
                @(negedge clk);
                start <= 1'b0;
                while (expected_weights.size() != 0)
                    @(negedge clk);
            end
            q = random_query();
            send_query(q, predict_weights(q));
            if (i % 200 < 150)
                idle_gap();
        end

        @(negedge clk);
        start <= 1'b0;
        while (expected_weights.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (!failed && expected_weights.size() == 0)
            $display("barycentric_coordinates regression: pass");
        else
            $display("barycentric_coordinates regression: fail");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("barycentric_coordinates regression: fail");
        $finish;
    end

endmodule

// File: sim.f
sv/bary_pkg.sv
sv/bary_front.sv
sv/bary_gram.sv
sv/bary_div.sv
sv/barycentric_coordinates.sv
test/tb_barycentric_coordinates.sv
